// File: design/csrb_pkg.sv
// Shared types and constants for the clipped 2bpp sprite row blitter.
// No dependencies; the front, queue, back and top modules use this package.
`default_nettype none

package csrb_pkg;

  localparam int unsigned ADDR_W      = 11;
  localparam int unsigned STORE_DEPTH = 2048;

  // Action codes carried on the input tuser.
  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // One classified command, handed from the front to the back.
  typedef struct packed {
    logic              is_read;
    logic [ADDR_W-1:0] addr0;
    logic [7:0]        mask0;
    logic [7:0]        data0;
    logic [ADDR_W-1:0] addr1;
    logic [7:0]        mask1;
    logic [7:0]        data1;
    logic              drawn;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/csrb_front.sv
// Front end: clips one sprite row and turns it into up to two masked byte merges.
// Depends on csrb_pkg (cmd_t, action codes).
`default_nettype none

module csrb_front #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned BYTES_PER_ROW = 32
) (
  input  wire logic                       action,
  input  wire logic [7:0]                 pos_x,
  input  wire logic [7:0]                 top_y,
  input  wire logic [7:0]                 row_index,
  input  wire logic [7:0]                 row_count,
  input  wire logic [7:0]                 row_pattern,
  input  wire logic [csrb_pkg::ADDR_W-1:0] read_address,
  output csrb_pkg::cmd_t                  cmd
);

  logic signed [9:0] y_s;
  logic              row_ok;
  logic [11:0]       base;
  logic [9:0]        pxe;
  logic [7:0]        bc0;
  logic [7:0]        bc1;
  logic [11:0]       addr0;
  logic [11:0]       addr1;
  logic [7:0]        mask0;
  logic [7:0]        data0;
  logic [7:0]        mask1;
  logic [7:0]        data1;
  logic              any_px;

  assign y_s    = $signed({{2{top_y[7]}}, top_y}) + $signed({2'b00, row_index});
  assign row_ok = (row_index < row_count) && !y_s[9] &&
                  ($unsigned(y_s) < 10'(SCREEN_HEIGHT));

  // Row base address; y stays below 128 once row_ok holds.
  assign base  = 12'(y_s[6:0]) * 12'(BYTES_PER_ROW);
  assign pxe   = {{2{pos_x[7]}}, pos_x};
  assign bc0   = pxe[9:2];
  assign bc1   = bc0 + 8'd1;
  assign addr0 = base + 12'(bc0);
  assign addr1 = base + 12'(bc1);

  always_comb begin
    logic [9:0]  col;
    logic [2:0]  sum;
    logic [2:0]  sh;
    logic [7:0]  pm;
    logic [7:0]  pd;
    logic [1:0]  pix;
    logic        ok;
    mask0  = '0;
    data0  = '0;
    mask1  = '0;
    data1  = '0;
    any_px = 1'b0;
    for (int i = 0; i < 4; i++) begin
      col = pxe + 10'(i);
      sum = {1'b0, pos_x[1:0]} + 3'(i);
      sh  = 3'd6 - {sum[1:0], 1'b0};
      pix = row_pattern[7-2*i -: 2];
      pm  = 8'b0000_0011 << sh;
      pd  = {6'b0, pix} << sh;
      // A pixel lands only if its column, byte column and address all fit.
      ok  = row_ok && !col[9] && (col < 10'(SCREEN_WIDTH)) &&
            (col[9:2] < 8'(BYTES_PER_ROW)) &&
            !(sum[2] ? addr1[11] : addr0[11]);
      if (ok) begin
        any_px = 1'b1;
        if (sum[2]) begin
          mask1 = mask1 | pm;
          data1 = data1 | pd;
        end else begin
          mask0 = mask0 | pm;
          data0 = data0 | pd;
        end
      end
    end
  end

  always_comb begin
    cmd.is_read = (action == csrb_pkg::ACT_READ);
    cmd.addr0   = cmd.is_read ? read_address : addr0[csrb_pkg::ADDR_W-1:0];
    cmd.mask0   = cmd.is_read ? 8'h00 : mask0;
    cmd.data0   = data0;
    cmd.addr1   = addr1[csrb_pkg::ADDR_W-1:0];
    cmd.mask1   = cmd.is_read ? 8'h00 : mask1;
    cmd.data1   = data1;
    cmd.drawn   = !cmd.is_read && any_px;
  end

endmodule

`default_nettype wire

// File: design/csrb_queue.sv
// Two-entry command queue between the front and the back.
// Depends on csrb_pkg (cmd_t).
`default_nettype none

module csrb_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  csrb_pkg::cmd_t      push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output csrb_pkg::cmd_t      head
);

  csrb_pkg::cmd_t ent_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");

endmodule

`default_nettype wire

// File: design/csrb_back.sv
// Back end: owns the single-port frame store, clears it after reset and runs
// each queued command: a store read, or a read-modify-write per drawn byte. Depends on csrb_pkg.
`default_nettype none

module csrb_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  csrb_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [15:0]         out_tdata
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_RD0   = 8'b0000_1000,
    S_WR0   = 8'b0001_0000,
    S_RD1   = 8'b0010_0000,
    S_WR1   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                      state_r, state_nxt;
  csrb_pkg::cmd_t              cur_r;
  logic [csrb_pkg::ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_data_r;
  logic                        out_drawn_r;
  logic                        out_load;

  logic [7:0]                  mem [csrb_pkg::STORE_DEPTH];
  logic [7:0]                  rd_q;
  logic                        mem_we;
  logic                        mem_re;
  logic [csrb_pkg::ADDR_W-1:0] mem_addr;
  logic [7:0]                  mem_wd;

  assign clearing   = (state_r == S_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_drawn_r, out_data_r};
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = cur_r.addr0;
    mem_wd      = 8'h00;
    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + {{(csrb_pkg::ADDR_W-1){1'b0}}, 1'b1};
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.is_read) begin
            state_nxt = S_RD;
          end else if (q_cmd.mask0 != 8'h00) begin
            state_nxt = S_RD0;
          end else if (q_cmd.mask1 != 8'h00) begin
            state_nxt = S_RD1;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_DONE;
      end
      S_RD0: begin
        mem_re    = 1'b1;
        state_nxt = S_WR0;
      end
      S_WR0: begin
        mem_we    = 1'b1;
        mem_wd    = (rd_q & ~cur_r.mask0) | (cur_r.data0 & cur_r.mask0);
        state_nxt = (cur_r.mask1 != 8'h00) ? S_RD1 : S_DONE;
      end
      S_RD1: begin
        mem_re    = 1'b1;
        mem_addr  = cur_r.addr1;
        state_nxt = S_WR1;
      end
      S_WR1: begin
        mem_we    = 1'b1;
        mem_addr  = cur_r.addr1;
        mem_wd    = (rd_q & ~cur_r.mask1) | (cur_r.data1 & cur_r.mask1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    if (out_load) begin
      out_data_r  <= cur_r.is_read ? rd_q : 8'h00;
      out_drawn_r <= cur_r.drawn;
    end
  end

  // Single-port frame store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  a_one_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re)) else $error("frame store read and write in one cycle");
  a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing) |-> $past(clr_cnt_r) == '1)
    else $error("clearing pass left early");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("command taken while busy");
  // A read result follows the store read, possibly after waiting on the output.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && cur_r.is_read |-> ($past(state_r) == S_RD || $past(state_r) == S_DONE))
    else $error("read result without a store read");

endmodule

`default_nettype wire

// File: design/clipped_sprite_row_blitter_2bpp_top.sv
// Top level of the clipped 2bpp sprite row blitter: front, queue and back.
// Depends on csrb_pkg, csrb_front, csrb_queue and csrb_back.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_tvalid/tready   | tuser action; tdata row fields, read address
//  out     | out | out_tvalid/tready  | tdata read_data, row_drawn
//
// In the back, a read is one store read, a draw one store byte or two, and a
// fully clipped row no store access; each byte is a read then a write on the
// single frame store port. After reset the store is cleared, one byte a cycle
// for all 2048 bytes, and no item is taken in that time. The two-entry queue lets
// the front accept up to two commands while the back works or the output is stalled.
`default_nettype none

module clipped_sprite_row_blitter_2bpp_top #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned BYTES_PER_ROW = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // pos_x, top_y, row_index, row_count,
                                       // row_pattern, read_address, zero pad
  input  wire logic        in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // read_data, row_drawn, zero pad
);

  csrb_pkg::cmd_t front_cmd;
  csrb_pkg::cmd_t head_cmd;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic           clearing;
  logic           push;

  assign in_tready = !q_full && !clearing;
  assign push      = in_tvalid && in_tready;

  csrb_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .BYTES_PER_ROW(BYTES_PER_ROW)
  ) u_front (
    .action      (in_tuser),
    .pos_x       (in_tdata[7:0]),
    .top_y       (in_tdata[15:8]),
    .row_index   (in_tdata[23:16]),
    .row_count   (in_tdata[31:24]),
    .row_pattern (in_tdata[39:32]),
    .read_address(in_tdata[50:40]),
    .cmd         (front_cmd)
  );

  csrb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (head_cmd)
  );

  csrb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

// File: tb/clipped_sprite_row_blitter_2bpp_top_test.sv
// Self-checking bench for the clipped 2bpp sprite row blitter top level.
// Keeps a mirror of the frame store, predicts each reply and compares it beat by beat.
// Depends on csrb_pkg and clipped_sprite_row_blitter_2bpp_top.
`default_nettype none

module clipped_sprite_row_blitter_2bpp_top_test;

  localparam int SCR_W     = 128;
  localparam int SCR_H     = 64;
  localparam int ROW_BYTES = 32;
  localparam int N_ITEMS   = 550;
  localparam int HOLD_CYC  = 300;

  typedef struct {
    logic        action;
    logic [7:0]  pos_x;
    logic [7:0]  top_y;
    logic [7:0]  row_index;
    logic [7:0]  row_count;
    logic [7:0]  row_pattern;
    logic [10:0] read_address;
  } blit_cmd_t;

  typedef struct {
    logic [7:0] read_data;
    logic       row_drawn;
  } blit_reply_t;

  // Mirror of the frame store plus the replies still owed by the block.
  class frame_mirror;
    logic [7:0]  image [csrb_pkg::STORE_DEPTH];
    blit_reply_t pending_replies[$];
    int          failures;

    function new();
      foreach (image[a]) image[a] = 8'h00;
      failures = 0;
    endfunction

    function blit_reply_t predict_reply(blit_cmd_t c);
      blit_reply_t r;
      int          px;
      int          row;
      int          col;
      int          bcol;
      int          addr;
      int          sh;
      logic [7:0]  pix;
      r.read_data = 8'h00;
      r.row_drawn = 1'b0;
      if (c.action == csrb_pkg::ACT_READ) begin
        r.read_data = image[c.read_address];
        return r;
      end
      px  = $signed(c.pos_x);
      row = $signed(c.top_y);
      row = row + int'(c.row_index);
      if (c.row_index < c.row_count && row >= 0 && row < SCR_H) begin
        for (int i = 0; i < 4; i++) begin
          col = px + i;
          if (col < 0 || col >= SCR_W) continue;
          bcol = col >> 2;
          if (bcol >= ROW_BYTES) continue;
          addr = row * ROW_BYTES + bcol;
          if (addr >= csrb_pkg::STORE_DEPTH) continue;
          pix = (c.row_pattern >> (6 - 2 * i)) & 8'h03;
          sh = 6 - 2 * (col & 3);
          image[addr] = (image[addr] & ~(8'h03 << sh)) | (pix << sh);
          r.row_drawn = 1'b1;
        end
      end
      return r;
    endfunction

    function void apply_beat(blit_cmd_t c);
      pending_replies.push_back(predict_reply(c));
    endfunction

    function void check_beat(logic [15:0] tdata);
      blit_reply_t want;
      if (pending_replies.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected output beat: tdata=%h", tdata);
        return;
      end
      want = pending_replies.pop_front();
      if (tdata[7:0] !== want.read_data || tdata[8] !== want.row_drawn) begin
        failures++;
        if (failures <= 10)
          $display("reply mismatch: read_data exp %h got %h, row_drawn exp %b got %b",
                   want.read_data, tdata[7:0], want.row_drawn, tdata[8]);
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  frame_mirror mirror;
  int          beats_sent;
  int          burst_left;
  bit          hold_req;
  int          hold_left;
  int          rx_mode;
  int          rx_phase;

  clipped_sprite_row_blitter_2bpp_top #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H),
    .BYTES_PER_ROW(ROW_BYTES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic blit_cmd_t draw_cmd(int px, int ty, int ri, int rc, logic [7:0] pat);
    blit_cmd_t c;
    c.action       = csrb_pkg::ACT_DRAW;
    c.pos_x        = px[7:0];
    c.top_y        = ty[7:0];
    c.row_index    = ri[7:0];
    c.row_count    = rc[7:0];
    c.row_pattern  = pat;
    c.read_address = 11'($urandom);
    return c;
  endfunction

  function automatic blit_cmd_t read_cmd(int addr);
    blit_cmd_t c;
    c.action       = csrb_pkg::ACT_READ;
    c.pos_x        = 8'($urandom);
    c.top_y        = 8'($urandom);
    c.row_index    = 8'($urandom);
    c.row_count    = 8'($urandom);
    c.row_pattern  = 8'($urandom);
    c.read_address = addr[10:0];
    return c;
  endfunction

  // Offer one beat from the falling edge and hold it until the block takes it.
  task automatic send_cmd(blit_cmd_t c);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= c.action;
    in_tdata  <= {5'b0, c.read_address, c.row_pattern, c.row_count,
                  c.row_index, c.top_y, c.pos_x};
    do @(posedge clk); while (!in_tready);
    mirror.apply_beat(c);
    beats_sent++;
    if (beats_sent == 200 || beats_sent == 420) hold_req = 1'b1;
    pace_sender();
  endtask

  // Bursts of random length separated by random gaps; some bursts are long.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 10);
    end
  endtask

  // Receiver: its own stall pattern, picked at random among four modes, plus long hold-offs.
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    rx_mode    = 0;
    rx_phase   = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYC - 1;
        out_tready <= 1'b0;
      end else begin
        rx_phase++;
        if (rx_phase % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= (rx_phase % 8 < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mirror.check_beat(out_tdata);
  end

  initial begin
    #2_000_000;
    $display("clipped_sprite_row_blitter_2bpp_top verification failed");
    $finish;
  end

  initial begin
    blit_cmd_t c;
    int        px;
    int        ty;
    int        rc;
    int        extra;
    int        pick;
    mirror     = new();
    beats_sent = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = csrb_pkg::ACT_DRAW;
    in_tdata   = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: store cleared, edge columns and rows, rows past the sprite.
    send_cmd(read_cmd(0));
    send_cmd(read_cmd(2047));
    send_cmd(draw_cmd(0, 0, 0, 1, 8'he4));
    send_cmd(draw_cmd(2, 0, 1, 2, 8'hff));
    send_cmd(draw_cmd(-1, 5, 0, 1, 8'h1b));
    send_cmd(draw_cmd(-3, 6, 0, 1, 8'hff));
    send_cmd(draw_cmd(-4, 7, 0, 1, 8'hff));
    send_cmd(draw_cmd(-128, 8, 0, 1, 8'hff));
    send_cmd(draw_cmd(125, 9, 0, 1, 8'hb4));
    send_cmd(draw_cmd(126, 10, 0, 1, 8'hff));
    send_cmd(draw_cmd(127, 11, 0, 1, 8'hff));
    send_cmd(draw_cmd(124, 63, 0, 1, 8'h6c));
    send_cmd(draw_cmd(0, -128, 255, 255, 8'hff));
    send_cmd(draw_cmd(4, 12, 3, 3, 8'hff));
    send_cmd(draw_cmd(4, 12, 0, 0, 8'hff));
    send_cmd(draw_cmd(4, 60, 4, 8, 8'hff));
    send_cmd(draw_cmd(4, -1, 0, 2, 8'hff));
    send_cmd(draw_cmd(4, -1, 1, 2, 8'h93));
    send_cmd(draw_cmd(127, 127, 255, 0, 8'hff));
    send_cmd(draw_cmd(0, 0, 0, 1, 8'h00));
    send_cmd(read_cmd(0));
    send_cmd(read_cmd(32));
    send_cmd(read_cmd(33));
    send_cmd(read_cmd(2047));
    send_cmd(read_cmd(11 * ROW_BYTES + 31));

    // Random: mostly whole sprites landing near or on screen, with reads and noise mixed in.
    while (beats_sent < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        px    = int'($urandom_range(0, 135)) - 4;
        ty    = int'($urandom_range(0, 71)) - 8;
        rc    = $urandom_range(1, 8);
        extra = ($urandom_range(0, 3) == 0) ? 1 : 0;
        for (int ri = 0; ri < rc + extra; ri++)
          send_cmd(draw_cmd(px, ty, ri, rc, 8'($urandom)));
      end else if (pick < 85) begin
        if ($urandom_range(0, 1) == 0)
          send_cmd(read_cmd($urandom_range(0, csrb_pkg::STORE_DEPTH - 1)));
        else
          send_cmd(read_cmd($urandom_range(0, SCR_H - 1) * ROW_BYTES
                            + $urandom_range(0, ROW_BYTES - 1)));
      end else begin
        c = read_cmd($urandom_range(0, csrb_pkg::STORE_DEPTH - 1));
        c.action = ($urandom_range(0, 1) == 0) ? csrb_pkg::ACT_DRAW : csrb_pkg::ACT_READ;
        send_cmd(c);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mirror.failures == 0) begin
      $display("clipped_sprite_row_blitter_2bpp_top verification clean");
    end else begin
      $display("clipped_sprite_row_blitter_2bpp_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
